[hdl/cfpa_pkg.sv]
// Shared types, constants and helpers of the complex fixed-point ALU.
`default_nettype none
package cfpa_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NCELL      = 64 + FRAC_BITS;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_MOD  = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]       op;
        logic [31:0]      rr;
        logic [31:0]      ri;
        logic             ovf;
        logic             dz;
        logic [63:0]      den;
        logic [1:0][63:0] d_num;
        logic [1:0][63:0] d_rem;
        logic [1:0][32:0] d_quo;
        logic [1:0]       d_big;
        logic [1:0]       d_neg;
        logic [63:0]      s_rad;
        logic [33:0]      s_rem;
        logic [31:0]      s_root;
    } t_cell;

    typedef struct packed {
        logic [31:0] rr;
        logic [31:0] ri;
        logic        dz;
        logic        ovf;
    } t_res;

    // {overflow, value} of a signed value clamped to 32 bits
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/complex_fixed_point_alu_top.sv]
// The pipeline has two operand stages, one chain cell per quotient bit (64 + fraction bits)
// and one output register.
// Throughput: one item per cycle; the chain takes a new item every cycle it advances.
// The divide chain, one restoring step per cell, sets the latency; the root uses its last 32 cells.
// Reset clears the valid flags of every stage and of the output buffer; data is not cleared.
`default_nettype none
module complex_fixed_point_alu_top import cfpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [2:0]  i_opcode,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic               o_div_zero,
    output logic               o_overflow
);

    logic           w_en;
    logic [NCELL:0] w_valid;
    t_cell          w_data [NCELL+1];
    t_res           w_res, w_out;

    cfpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .o_valid  (w_valid[0]),
        .o_data   (w_data[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cfpa_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_sqrt_en (k >= NCELL - SQRT_STEPS),
            .i_valid   (w_valid[k]),
            .i_data    (w_data[k]),
            .o_valid   (w_valid[k+1]),
            .o_data    (w_data[k+1])
        );
    end

    t_cell       w_last;
    logic [1:0]  w_dovf;
    logic [31:0] w_dres [2];

    assign w_last = w_data[NCELL];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            if (w_last.d_neg[j]) begin
                w_dovf[j] = w_last.d_big[j] || (w_last.d_quo[j] > 33'd2147483648);
                w_dres[j] = w_dovf[j] ? 32'h8000_0000 : (32'd0 - w_last.d_quo[j][31:0]);
            end else begin
                w_dovf[j] = w_last.d_big[j] || (w_last.d_quo[j] > 33'd2147483647);
                w_dres[j] = w_dovf[j] ? 32'h7fff_ffff : w_last.d_quo[j][31:0];
            end
        end
        w_res.rr  = w_last.rr;
        w_res.ri  = w_last.ri;
        w_res.dz  = 1'b0;
        w_res.ovf = w_last.ovf;
        case (t_op'(w_last.op))
            OP_DIV: begin
                if (w_last.dz) begin
                    w_res = '{rr: '0, ri: '0, dz: 1'b1, ovf: 1'b0};
                end else begin
                    w_res.rr  = w_dres[0];
                    w_res.ri  = w_dres[1];
                    w_res.ovf = |w_dovf;
                end
            end
            OP_MOD: begin
                w_res.rr  = w_last.s_root[31] ? 32'h7fff_ffff : w_last.s_root;
                w_res.ri  = '0;
                w_res.ovf = w_last.s_root[31];
            end
            default: begin
            end
        endcase
    end

    cfpa_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NCELL]),
        .i_data  (w_res),
        .o_ready (w_en),
        .o_valid (o_valid),
        .o_data  (w_out),
        .i_ready (i_ready)
    );

    assign o_ready    = w_en;
    assign o_res_real = w_out.rr;
    assign o_res_imag = w_out.ri;
    assign o_div_zero = w_out.dz;
    assign o_overflow = w_out.ovf;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_real == 0 && o_res_imag == 0 && !o_overflow)
        else $error("divide by zero result not cleared");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NCELL] && !w_en |=> w_valid[NCELL] && $stable(w_res))
        else $error("chain end lost an item while stalled");

    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> o_valid)
        else $error("skid full without a pending result");

endmodule
`default_nettype wire

[hdl/cfpa_front.sv]
// Operand stages: products, simple results and setup of the divide and root chain.
`default_nettype none
module cfpa_front import cfpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic        [2:0]  i_opcode,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    output logic               o_valid,
    output t_cell              o_data
);

    logic               r_v1;
    logic [2:0]         r_op;
    logic [31:0]        r_rr;
    logic [31:0]        r_ri;
    logic               r_ovf;
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_x, r_sq_y;
    logic               r_v2;
    t_cell              r_cell;

    logic [32:0]        n_sr, n_si;
    logic signed [31:0] w_sx, w_sy;
    logic signed [32:0] w_zero33;

    assign w_zero33 = '0;

    always_comb begin
        n_sr = '0;
        n_si = '0;
        case (t_op'(i_opcode))
            OP_ADD: begin
                n_sr = sat32(33'(i_a_real) + 33'(i_b_real));
                n_si = sat32(33'(i_a_imag) + 33'(i_b_imag));
            end
            OP_SUB: begin
                n_sr = sat32(33'(i_a_real) - 33'(i_b_real));
                n_si = sat32(33'(i_a_imag) - 33'(i_b_imag));
            end
            OP_CONJ: begin
                n_sr = {1'b0, i_b_real};
                n_si = sat32(w_zero33 - 33'(i_b_imag));
            end
            default: begin
                n_sr = '0;
                n_si = '0;
            end
        endcase
        w_sx = (t_op'(i_opcode) == OP_MOD) ? i_a_real : i_b_real;
        w_sy = (t_op'(i_opcode) == OP_MOD) ? i_a_imag : i_b_imag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_op   <= i_opcode;
            r_rr   <= n_sr[31:0];
            r_ri   <= n_si[31:0];
            r_ovf  <= n_sr[32] | n_si[32];
            r_p_rr <= i_a_real * i_b_real;
            r_p_ii <= i_a_imag * i_b_imag;
            r_p_ri <= i_a_real * i_b_imag;
            r_p_ir <= i_a_imag * i_b_real;
            r_sq_x <= w_sx * w_sx;
            r_sq_y <= w_sy * w_sy;
        end
    end

    logic signed [64:0] w_m_re, w_m_im, w_n_re, w_n_im, w_a_re, w_a_im;
    logic [32:0]        w_mr, w_mi;
    logic [63:0]        w_sum_sq;
    t_cell              n_cell;

    assign w_m_re   = r_p_rr - r_p_ii;
    assign w_m_im   = r_p_ri + r_p_ir;
    assign w_n_re   = r_p_rr + r_p_ii;
    assign w_n_im   = r_p_ir - r_p_ri;
    assign w_a_re   = w_n_re[64] ? -w_n_re : w_n_re;
    assign w_a_im   = w_n_im[64] ? -w_n_im : w_n_im;
    assign w_mr     = sat32(w_m_re >>> FRAC_BITS);
    assign w_mi     = sat32(w_m_im >>> FRAC_BITS);
    assign w_sum_sq = $unsigned(r_sq_x) + $unsigned(r_sq_y);

    always_comb begin
        n_cell        = '0;
        n_cell.op     = r_op;
        n_cell.rr     = r_rr;
        n_cell.ri     = r_ri;
        n_cell.ovf    = r_ovf;
        if (t_op'(r_op) == OP_MUL) begin
            n_cell.rr  = w_mr[31:0];
            n_cell.ri  = w_mi[31:0];
            n_cell.ovf = w_mr[32] | w_mi[32];
        end
        n_cell.dz       = (t_op'(r_op) == OP_DIV) && (w_sum_sq == '0);
        n_cell.den      = w_sum_sq;
        n_cell.d_num[0] = w_a_re[63:0];
        n_cell.d_num[1] = w_a_im[63:0];
        n_cell.d_neg    = {w_n_im[64], w_n_re[64]};
        n_cell.s_rad    = w_sum_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_cell;

endmodule
`default_nettype wire

[hdl/cfpa_cell.sv]
// One chain cell: a quotient bit for both divide lanes and, when enabled, a root bit.
`default_nettype none
module cfpa_cell import cfpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_sqrt_en,
    input  logic  i_valid,
    input  t_cell i_data,
    output logic  o_valid,
    output t_cell o_data
);

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;

    logic [64:0] w_rsh  [2];
    logic [64:0] w_diff [2];
    logic [1:0]  w_ge;
    logic [35:0] w_ssh, w_trial, w_sdiff;
    logic        w_sge;

    always_comb begin
        n_data = i_data;
        for (int j = 0; j < 2; j++) begin
            w_rsh[j]  = {i_data.d_rem[j], i_data.d_num[j][63]};
            w_ge[j]   = w_rsh[j] >= {1'b0, i_data.den};
            w_diff[j] = w_rsh[j] - {1'b0, i_data.den};
            n_data.d_rem[j] = w_ge[j] ? w_diff[j][63:0] : w_rsh[j][63:0];
            n_data.d_num[j] = {i_data.d_num[j][62:0], 1'b0};
            n_data.d_quo[j] = {i_data.d_quo[j][31:0], w_ge[j]};
            n_data.d_big[j] = i_data.d_big[j] | i_data.d_quo[j][32];
        end
        w_ssh   = {i_data.s_rem, i_data.s_rad[63:62]};
        w_trial = {2'b00, i_data.s_root, 2'b01};
        w_sge   = w_ssh >= w_trial;
        w_sdiff = w_ssh - w_trial;
        if (i_sqrt_en) begin
            n_data.s_rem  = w_sge ? w_sdiff[33:0] : w_ssh[33:0];
            n_data.s_root = {i_data.s_root[30:0], w_sge};
            n_data.s_rad  = {i_data.s_rad[61:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[hdl/cfpa_skid.sv]
// Output register with a skid stage behind it.
`default_nettype none
module cfpa_skid import cfpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_res i_data,
    output logic o_ready,
    output logic o_valid,
    output t_res o_data,
    input  logic i_ready
);

    logic r_out_valid, r_sk_valid;
    t_res r_out, r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= r_sk_valid | i_valid;
            r_sk_valid  <= 1'b0;
        end else if (i_valid && !r_sk_valid) begin
            r_sk_valid <= 1'b1;
        end
        if (!r_out_valid || i_ready) begin
            r_out <= r_sk_valid ? r_sk : i_data;
        end else if (i_valid && !r_sk_valid) begin
            r_sk <= i_data;
        end
    end

    assign o_ready = !r_sk_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

[bench/cfpa_checker.sv]
// Checker: watches both channels, predicts each result and compares it with the block's output.
`timescale 1ns / 100ps
`default_nettype none
module cfpa_checker import cfpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic        [2:0]  i_opcode,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_res_real,
    input  logic signed [31:0] i_res_imag,
    input  logic               i_div_zero,
    input  logic               i_overflow,
    output int                 o_errors,
    output int                 o_pending
);

    t_res result_fifo[$];
    int   error_count = 0;
    int   pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
        logic [31:0] r;
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            r = 32'h7fff_ffff;
        end else if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] quotient_part(input logic signed [127:0] num,
                                                  input logic [127:0] den, inout logic ovf);
        logic        neg;
        logic [127:0] mag;
        logic [127:0] q;
        logic [31:0] r;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag << FRAC_BITS) / den;
        if (neg) begin
            if (q > 128'd2147483648) begin
                ovf = 1'b1;
                r = 32'h8000_0000;
            end else begin
                r = -q[31:0];
            end
        end else if (q > 128'd2147483647) begin
            ovf = 1'b1;
            r = 32'h7fff_ffff;
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] radicand);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem = radicand;
        root = 0;
        probe = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= root + probe) begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic t_res predict_alu(input logic [2:0] op,
                                         input logic signed [31:0] ar, input logic signed [31:0] ai,
                                         input logic signed [31:0] br, input logic signed [31:0] bi);
        t_res r;
        logic signed [127:0] xr, xi, yr, yi, den;
        logic [63:0] m;
        logic ovf;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        ovf = 1'b0;
        r = '0;
        case (op)
            OP_ADD: begin
                r.rr = clamp32(xr + yr, ovf);
                r.ri = clamp32(xi + yi, ovf);
            end
            OP_SUB: begin
                r.rr = clamp32(xr - yr, ovf);
                r.ri = clamp32(xi - yi, ovf);
            end
            OP_MUL: begin
                r.rr = clamp32((xr * yr - xi * yi) >>> FRAC_BITS, ovf);
                r.ri = clamp32((xr * yi + xi * yr) >>> FRAC_BITS, ovf);
            end
            OP_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    r.rr = quotient_part(yr * xr + yi * xi, den, ovf);
                    r.ri = quotient_part(yr * xi - yi * xr, den, ovf);
                end
            end
            OP_CONJ: begin
                r.rr = br;
                r.ri = clamp32(-yi, ovf);
            end
            OP_MOD: begin
                den = xr * xr + xi * xi;
                m = floor_root(den[63:0]);
                if (m > 64'd2147483647) begin
                    ovf = 1'b1;
                    m = 64'd2147483647;
                end
                r.rr = m[31:0];
            end
            default: ;
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (result_fifo.size() == 0) begin
                    report_mismatch("unexpected transfer", i_res_real, 32'h0);
                end else begin
                    want = result_fifo.pop_front();
                    if (i_res_real !== want.rr) report_mismatch("res_real", i_res_real, want.rr);
                    if (i_res_imag !== want.ri) report_mismatch("res_imag", i_res_imag, want.ri);
                    if (i_div_zero !== want.dz) begin
                        report_mismatch("div_zero", 32'(i_div_zero), 32'(want.dz));
                    end
                    if (i_overflow !== want.ovf) begin
                        report_mismatch("overflow", 32'(i_overflow), 32'(want.ovf));
                    end
                end
            end
            if (i_valid && i_in_ready) begin
                result_fifo.push_back(predict_alu(i_opcode, i_a_real, i_a_imag,
                                                  i_b_real, i_b_imag));
            end
            pending_count = result_fifo.size();
        end
    end

endmodule
`default_nettype wire

[bench/tb_complex_fixed_point_alu_top.sv]
// Testbench top: drives operand transfers, stalls the result channel and gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_complex_fixed_point_alu_top;
    import cfpa_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 310;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic        [2:0]  i_opcode = '0;
    logic signed [31:0] i_a_real = '0;
    logic signed [31:0] i_a_imag = '0;
    logic signed [31:0] i_b_real = '0;
    logic signed [31:0] i_b_imag = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_res_real;
    logic signed [31:0] o_res_imag;
    logic               o_div_zero;
    logic               o_overflow;

    int errors;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #2 i_clk = ~i_clk;

    complex_fixed_point_alu_top dut (.*);

    cfpa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_ready(o_ready), .i_opcode(i_opcode),
        .i_a_real(i_a_real), .i_a_imag(i_a_imag), .i_b_real(i_b_real), .i_b_imag(i_b_imag),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_res_real(o_res_real), .i_res_imag(o_res_imag),
        .i_div_zero(o_div_zero), .i_overflow(o_overflow),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_complex_fixed_point_alu_top NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'h0;
            3: v = 32'hffff_ffff;
            4, 5: begin
                v = $urandom_range(0, 32'h3_ffff);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random();
        logic [2:0] op;
        logic [31:0] br, bi;
        op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                          : 3'($urandom_range(OP_ADD, OP_MOD));
        br = pick_operand();
        bi = pick_operand();
        case ($urandom_range(0, 9))
            0: begin br = 0; bi = 0; end
            1: bi = 0;
            default: ;
        endcase
        send_item(op, pick_operand(), pick_operand(), br, bi);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_ADD,  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_ADD,  32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0);
        send_item(OP_SUB,  32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
        send_item(OP_SUB,  32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_item(OP_MUL,  32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000);
        send_item(OP_MUL,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL,  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_MUL,  32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
        send_item(OP_DIV,  32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_item(OP_DIV,  32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(OP_DIV,  32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0);
        send_item(OP_DIV,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_DIV,  32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_CONJ, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_CONJ, 32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(OP_MOD,  32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_item(OP_MOD,  32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
        send_item(OP_MOD,  32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
        send_item(OP_MOD,  32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_SPARE_LO, 32'h7fff_ffff, 32'h1, 32'h2, 32'h3);
        send_item(OP_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2 && phase == 2) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                send_random();
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_complex_fixed_point_alu_top OK");
        end else begin
            $display("tb_complex_fixed_point_alu_top NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
